// ----- sv/orl_pkg.sv -----
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types and constants of the ordered record list.
// ----------------------------------------------------------------------------
`default_nettype none

package orl_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned NAME_BITS_DEF = 64;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned DATE_W  = DAY_W + MONTH_W + YEAR_W;
  localparam int unsigned FIDX_W  = 4;
  localparam int unsigned ECNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ----- sv/orl_ram.sv -----
// ----------------------------------------------------------------------------
// orl_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module orl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/ordered_record_list.sv -----
// ----------------------------------------------------------------------------
// ordered_record_list
// Fixed-capacity ordered list of name/date records with insert, remove and
// search, walked through one record RAM by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Rejects and removal of the last entry answer straight from idle, an append
//   goes through S_PLACE; other inserts and removes walk S_WALK to move entries,
//   inserts then S_PLACE; search walks from index 0 to a match or the last entry.
// One request at a time, walked through the one read and one write port of the
//   record RAM; start_i is taken only in idle, and busy_o drops as done_o rises.
// Reset clears the entry count and result registers; record storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_record_list
  import orl_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned NAME_BITS = NAME_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [KEY_W-1:0]   name_key_i,
  input  wire logic [DAY_W-1:0]   day_i,
  input  wire logic [MONTH_W-1:0] month_i,
  input  wire logic [YEAR_W-1:0]  year_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [FIDX_W-1:0]       found_index_o,
  output logic [KEY_W-1:0]        found_name_o,
  output logic [DAY_W-1:0]        found_day_o,
  output logic [MONTH_W-1:0]      found_month_o,
  output logic [YEAR_W-1:0]       found_year_o,
  output logic [ECNT_W-1:0]       entry_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned ENT_W = NAME_BITS + DATE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PLACE
  } state_e;

  state_e                 state_q;
  action_e                op_q;
  logic [CNT_W-1:0]       count_q;
  logic [IDX_W-1:0]       ptr_q;
  logic [IDX_W-1:0]       end_q;
  logic                   iss_q;
  logic                   rv_q;
  logic [IDX_W-1:0]       rv_addr_q;
  logic [IDX_W-1:0]       pos_q;
  logic [NAME_BITS-1:0]   key_q;
  logic [DATE_W-1:0]      date_q;
  logic                   done_q;
  status_e                status_q;
  logic [FIDX_W-1:0]      fidx_q;
  logic [KEY_W-1:0]       fname_q;
  logic [DATE_W-1:0]      fdate_q;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_wa;
  logic [ENT_W-1:0]       ram_wd;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_ra;
  logic [ENT_W-1:0]       ram_rd;

  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [NAME_BITS-1:0]   rd_name;
  logic [DATE_W-1:0]      rd_date;
  logic                   rd_last;
  logic                   hit;

  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign rd_name = ram_rd[ENT_W-1:DATE_W];
  assign rd_date = ram_rd[DATE_W-1:0];
  assign rd_last = (rv_addr_q == end_q);
  assign hit     = (rd_name == key_q);

  orl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .re_i    (ram_re),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_wa = pos_q;
    ram_wd = {key_q, date_q};
    ram_re = 1'b0;
    ram_ra = ptr_q;
    unique case (state_q)
      S_WALK: begin
        ram_re = iss_q;
        if (rv_q && (op_q != ACT_SEARCH)) begin
          ram_we = 1'b1;
          ram_wd = ram_rd;
          ram_wa = (op_q == ACT_INSERT) ? rv_addr_q + 1'b1 : rv_addr_q - 1'b1;
        end
      end
      S_PLACE: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      iss_q     <= 1'b0;
      rv_q      <= 1'b0;
      done_q    <= 1'b0;
      op_q      <= ACT_INSERT;
      ptr_q     <= '0;
      end_q     <= '0;
      rv_addr_q <= '0;
      pos_q     <= '0;
      key_q     <= '0;
      date_q    <= '0;
      status_q  <= ST_OK;
      fidx_q    <= '0;
      fname_q   <= '0;
      fdate_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          iss_q <= 1'b0;
          rv_q  <= 1'b0;
          if (start_i) begin
            op_q    <= action_e'(action_i);
            pos_q   <= IDX_W'(position_i);
            key_q   <= name_key_i[NAME_BITS-1:0];
            date_q  <= {year_i, month_i, day_i};
            fidx_q  <= '0;
            fname_q <= '0;
            fdate_q <= '0;
            unique case (action_e'(action_i))
              ACT_INSERT: begin
                if (cnt_ext == CMP_W'(CAPACITY)) begin
                  done_q   <= 1'b1;
                  status_q <= ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                  done_q   <= 1'b1;
                  status_q <= ST_RANGE;
                end else if (pos_ext == cnt_ext) begin
                  state_q <= S_PLACE;
                end else begin
                  state_q <= S_WALK;
                  ptr_q   <= IDX_W'(count_q - 1'b1);
                  end_q   <= IDX_W'(position_i);
                  iss_q   <= 1'b1;
                end
              end
              ACT_REMOVE: begin
                if (count_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                  done_q   <= 1'b1;
                  status_q <= ST_RANGE;
                end else if (pos_ext + 1'b1 == cnt_ext) begin
                  done_q   <= 1'b1;
                  status_q <= ST_OK;
                  count_q  <= count_q - 1'b1;
                end else begin
                  state_q <= S_WALK;
                  ptr_q   <= IDX_W'(pos_ext + 1'b1);
                  end_q   <= IDX_W'(count_q - 1'b1);
                  iss_q   <= 1'b1;
                end
              end
              ACT_SEARCH: begin
                if (count_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= ST_EMPTY;
                end else begin
                  state_q <= S_WALK;
                  ptr_q   <= '0;
                  end_q   <= IDX_W'(count_q - 1'b1);
                  iss_q   <= 1'b1;
                end
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_RANGE;
              end
            endcase
          end
        end
        S_WALK: begin
          rv_q      <= iss_q;
          rv_addr_q <= ptr_q;
          if (iss_q) begin
            if (ptr_q == end_q) begin
              iss_q <= 1'b0;
            end else if (op_q == ACT_INSERT) begin
              ptr_q <= ptr_q - 1'b1;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
          if (rv_q) begin
            priority if (op_q == ACT_SEARCH && hit) begin
              state_q  <= S_IDLE;
              done_q   <= 1'b1;
              status_q <= ST_OK;
              fidx_q   <= FIDX_W'(rv_addr_q);
              fname_q  <= KEY_W'(rd_name);
              fdate_q  <= rd_date;
            end else if (rd_last) begin
              unique case (op_q)
                ACT_INSERT: begin
                  state_q <= S_PLACE;
                end
                ACT_REMOVE: begin
                  state_q  <= S_IDLE;
                  done_q   <= 1'b1;
                  status_q <= ST_OK;
                  count_q  <= count_q - 1'b1;
                end
                default: begin
                  state_q  <= S_IDLE;
                  done_q   <= 1'b1;
                  status_q <= ST_NOTFOUND;
                end
              endcase
            end else begin
            end
          end
        end
        S_PLACE: begin
          state_q  <= S_IDLE;
          done_q   <= 1'b1;
          status_q <= ST_OK;
          count_q  <= count_q + 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = fidx_q;
  assign found_name_o  = fname_q;
  assign found_day_o   = fdate_q[DAY_W-1:0];
  assign found_month_o = fdate_q[DAY_W+MONTH_W-1:DAY_W];
  assign found_year_o  = fdate_q[DATE_W-1:DAY_W+MONTH_W];
  assign entry_count_o = ECNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_read_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (CNT_W'(ram_ra) < count_q))
    else $error("read beyond stored entries");

  a_write_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CNT_W'(ram_wa) <= count_q))
    else $error("write beyond list end");

  a_count_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("entry count changed without a result");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered record list. Requests go in through
// the start/busy handshake with random gaps; a shadow list predicts every
// answer and each done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import orl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIST_DEPTH  = CAPACITY_DEF;
  localparam int          SETTLE      = CAPACITY_DEF + 4;
  localparam int          STALL_LIMIT = 4000;
  localparam int          MAX_REPORTS = 10;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [63:0] DUP_KEY     = 64'h0000_0042_4F42_4F42;
  localparam logic [63:0] TEXT_KEY    = 64'h0000_0041_4C49_4345;

  typedef struct packed {
    logic [KEY_W-1:0]   name;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } record_t;

  typedef struct packed {
    status_e             status;
    logic [FIDX_W-1:0]   fidx;
    logic [KEY_W-1:0]    name;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [ECNT_W-1:0]   count;
  } list_result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  logic [1:0]         action_i   = '0;
  logic [POS_W-1:0]   position_i = '0;
  logic [KEY_W-1:0]   name_key_i = '0;
  logic [DAY_W-1:0]   day_i      = '0;
  logic [MONTH_W-1:0] month_i    = '0;
  logic [YEAR_W-1:0]  year_i     = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic [FIDX_W-1:0]  found_index_o;
  logic [KEY_W-1:0]   found_name_o;
  logic [DAY_W-1:0]   found_day_o;
  logic [MONTH_W-1:0] found_month_o;
  logic [YEAR_W-1:0]  found_year_o;
  logic [ECNT_W-1:0]  entry_count_o;

  record_t      list_rec [LIST_DEPTH];
  int           list_count = 0;
  list_result_t pending_results [$];

  bit no_idle     = 1'b0;
  int items_sent  = 0;
  int results_checked = 0;
  int mismatches  = 0;
  int stall_cycles = 0;
  int status_seen [5] = '{default: 0};

  ordered_record_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .position_i    (position_i),
    .name_key_i    (name_key_i),
    .day_i         (day_i),
    .month_i       (month_i),
    .year_i        (year_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .found_name_o  (found_name_o),
    .found_day_o   (found_day_o),
    .found_month_o (found_month_o),
    .found_year_o  (found_year_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic record_t make_rec(logic [KEY_W-1:0] name, logic [DAY_W-1:0] day,
                                       logic [MONTH_W-1:0] month, logic [YEAR_W-1:0] year);
    record_t rec;
    rec.name  = name;
    rec.day   = day;
    rec.month = month;
    rec.year  = year;
    return rec;
  endfunction

  function automatic record_t random_rec(logic [KEY_W-1:0] name);
    return make_rec(name, DAY_W'($urandom_range(0, 31)), MONTH_W'($urandom_range(0, 12)),
                    YEAR_W'($urandom_range(0, 65535)));
  endfunction

  // Shadow list: apply one request and return the answer it must give.
  function automatic list_result_t apply_request(logic [1:0] act, logic [POS_W-1:0] pos,
                                                 record_t rec);
    list_result_t res;
    int           i;
    bit           hit;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    case (act)
      ACT_INSERT: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (pos > list_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = list_count; i > pos; i--) list_rec[i] = list_rec[i-1];
          list_rec[pos] = rec;
          list_count++;
        end
      end
      ACT_REMOVE: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_count; i++) list_rec[i] = list_rec[i+1];
          list_count--;
        end
      end
      ACT_SEARCH: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (i = 0; i < list_count; i++) begin
            if (!hit && list_rec[i].name == rec.name) begin
              hit = 1'b1;
              res.status = ST_OK;
              res.fidx   = FIDX_W'(i);
              res.name   = list_rec[i].name;
              res.day    = list_rec[i].day;
              res.month  = list_rec[i].month;
              res.year   = list_rec[i].year;
            end
          end
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.count = ECNT_W'(list_count);
    return res;
  endfunction

  // Leaves start_i high on return; the next call or drain runs in the same step.
  task automatic send_request(input logic [1:0] act, input logic [POS_W-1:0] pos,
                              input record_t rec);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    name_key_i <= rec.name;
    day_i      <= rec.day;
    month_i    <= rec.month;
    year_i     <= rec.year;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_request(act, pos, rec));
    items_sent++;
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && done_o) begin
      got.status = status_e'(status_o);
      got.fidx   = found_index_o;
      got.name   = found_name_o;
      got.day    = found_day_o;
      got.month  = found_month_o;
      got.year   = found_year_o;
      got.count  = entry_count_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with no request pending: status=%0d count=%0d",
                   $realtime, status_o, entry_count_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status_o < 5) status_seen[status_o]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch exp: st=%0d idx=%0d name=%h d=%0d m=%0d y=%0d cnt=%0d",
                     $realtime, want.status, want.fidx, want.name, want.day, want.month,
                     want.year, want.count);
            $display("[%0t]          got: st=%0d idx=%0d name=%h d=%0d m=%0d y=%0d cnt=%0d",
                     $realtime, got.status, got.fidx, got.name, got.day, got.month,
                     got.year, got.count);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic test_empty_list;
    send_request(ACT_REMOVE, 5'd0, random_rec(64'h0));
    send_request(ACT_SEARCH, 5'd0, random_rec(TEXT_KEY));
    send_request(ACT_INSERT, 5'd1, random_rec(TEXT_KEY));
    send_request(ACT_UNUSED, 5'd16, random_rec({$urandom, $urandom}));
  endtask

  task automatic test_fill_to_capacity;
    int k;
    send_request(ACT_INSERT, 5'd0, make_rec(64'h0, 5'd0, 4'd0, 16'd0));
    send_request(ACT_INSERT, 5'd1, make_rec('1, 5'd31, 4'd12, 16'hFFFF));
    send_request(ACT_INSERT, 5'd0, make_rec(TEXT_KEY, 5'd1, 4'd1, 16'd1999));
    for (k = 0; k < LIST_DEPTH - 3; k++)
      send_request(ACT_INSERT, POS_W'($urandom_range(0, list_count)),
                   random_rec((k % 3 == 0) ? DUP_KEY : {$urandom, $urandom}));
  endtask

  task automatic test_full_list_edges;
    send_request(ACT_INSERT, 5'd5, random_rec(TEXT_KEY));
    send_request(ACT_SEARCH, 5'd0, random_rec(DUP_KEY));
    send_request(ACT_SEARCH, 5'd0, random_rec({$urandom, $urandom}));
    send_request(ACT_REMOVE, 5'd16, random_rec(64'h0));
    send_request(ACT_REMOVE, 5'd15, random_rec(64'h0));
  endtask

  task automatic test_random_traffic(input int n_items, input bit grow);
    int         i;
    int         r;
    logic [1:0] act;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 3)                      act = ACT_UNUSED;
      else if (r < (grow ? 58 : 23))  act = ACT_INSERT;
      else if (r < 78)                act = ACT_REMOVE;
      else                            act = ACT_SEARCH;
      if ($urandom_range(0, 9) == 0)
        pos = POS_W'($urandom_range(0, 16));
      else if (act == ACT_INSERT)
        pos = POS_W'($urandom_range(0, (list_count < LIST_DEPTH) ? list_count
                                                                   : LIST_DEPTH - 1));
      else
        pos = (list_count > 0) ? POS_W'($urandom_range(0, list_count - 1)) : '0;
      if (act == ACT_SEARCH && list_count > 0 && $urandom_range(0, 3) != 0)
        key = list_rec[$urandom_range(0, list_count - 1)].name;
      else case ($urandom_range(0, 4))
        0:       key = DUP_KEY;
        1:       key = TEXT_KEY;
        2:       key = '1;
        default: key = {$urandom, $urandom};
      endcase
      send_request(act, pos, random_rec(key));
    end
  endtask

  initial begin
    int blk;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_fill_to_capacity();
    test_full_list_edges();
    drain();
    for (blk = 0; blk < 5; blk++) begin
      test_random_traffic(300, blk % 2 == 0);
      drain();
    end
    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d requests, checked %0d answers, %0d mismatches", items_sent,
             results_checked, mismatches);
    $display("Answers by status: ok %0d, empty %0d, full %0d, range %0d, not found %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
